// File: hdl/ufd_pkg.sv
// Package for the binary frame deframer: sync constants, parser phases,
// queue command and result kind codes. No dependencies.
package ufd_pkg;

  localparam logic [7:0]  SYNC_FIRST        = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND       = 8'h62;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    OP_SUM_FIRST = 3'd0,
    OP_SUM       = 3'd1,
    OP_PAYLOAD   = 3'd2,
    OP_CK_A      = 3'd3,
    OP_CK_B      = 3'd4
  } cmd_op_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } result_kind_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
  } cmd_t;

endpackage

// File: hdl/ufd_if.sv
// Channel interfaces of the deframer: received bytes, config writes, results.
// Plain valid/ready bundles; no package dependency.
interface ufd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload_len;
  modport source (output valid, output max_payload_len, input ready);
  modport sink (input valid, input max_payload_len, output ready);
endinterface

interface ufd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic [15:0] byte_index;
  logic [7:0]  data_byte;
  modport source (output valid, output result_kind, output frame_class, output frame_id,
                  output frame_length, output byte_index, output data_byte, input ready);
  modport sink (input valid, input result_kind, input frame_class, input frame_id,
                input frame_length, input byte_index, input data_byte, output ready);
endinterface

// File: hdl/ufd_front.sv
// Front end: sync hunt and header parse, turns each header, payload and checksum byte into a queue command.
// Depends on ufd_pkg and ufd_byte_if.
module ufd_front
  import ufd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  ufd_byte_if.sink     rx_i,
  input  logic [15:0]  max_len_i,
  output logic         cmd_valid_o,
  output cmd_t         cmd_o,
  input  logic         cmd_ready_i
);

  phase_e      phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] idx_inc;
  logic        accept;
  logic [7:0]  b;

  assign rx_i.ready = cmd_ready_i;
  assign accept     = rx_i.valid && cmd_ready_i;
  assign b          = rx_i.rx_byte;
  assign idx_inc    = idx_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      class_q <= 8'h00;
      id_q    <= 8'h00;
      len_q   <= 16'h0000;
      idx_q   <= 16'h0000;
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    class_d           = class_q;
    id_d              = id_q;
    len_d             = len_q;
    idx_d             = idx_q;
    cmd_valid_o       = 1'b0;
    cmd_o.op          = OP_SUM;
    cmd_o.data        = b;
    cmd_o.frame_class = class_q;
    cmd_o.frame_id    = id_q;
    cmd_o.frame_length = len_q;
    cmd_o.byte_index  = idx_q;
    if (accept) begin
      unique case (phase_q)
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            phase_d = PH_CLASS;
          end else if (b != SYNC_FIRST) begin
            phase_d = PH_HUNT;
          end
        end
        PH_CLASS: begin
          class_d     = b;
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_SUM_FIRST;
          phase_d     = PH_ID;
        end
        PH_ID: begin
          id_d        = b;
          cmd_valid_o = 1'b1;
          phase_d     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d       = {8'h00, b};
          cmd_valid_o = 1'b1;
          phase_d     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d       = {b, len_q[7:0]};
          idx_d       = 16'h0000;
          cmd_valid_o = 1'b1;
          if (len_d > max_len_i) begin
            phase_d = PH_HUNT;
          end else if (len_d == 16'h0000) begin
            phase_d = PH_CK_A;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_PAYLOAD;
          idx_d       = idx_inc;
          if (idx_inc >= len_q) begin
            phase_d = PH_CK_A;
          end
        end
        PH_CK_A: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_CK_A;
          phase_d     = PH_CK_B;
        end
        PH_CK_B: begin
          cmd_valid_o = 1'b1;
          cmd_o.op    = OP_CK_B;
          phase_d     = PH_HUNT;
        end
        default: begin
          phase_d = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

endmodule

// File: hdl/ufd_cmd_fifo.sv
// Short command queue between parser front end and checksum back end.
// Depends on ufd_pkg for the command type.
module ufd_cmd_fifo
  import ufd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: hdl/ufd_back.sv
// Back end: Fletcher-8 accumulation, checksum compare and the result register.
// Depends on ufd_pkg and ufd_result_if.
module ufd_back
  import ufd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_ready_o,
  ufd_result_if.source  res_o
);

  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_lo_q;
  logic        out_valid_q;
  result_kind_e kind_q, kind_d;
  logic [7:0]  class_q, id_q, data_q;
  logic [15:0] len_q, idx_q;
  logic        emits, out_free, pop;

  assign emits       = (cmd_i.op == OP_PAYLOAD) || (cmd_i.op == OP_CK_B);
  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_ready_o = !emits || out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    kind_d  = KIND_PAYLOAD;
    unique case (cmd_i.op)
      OP_SUM_FIRST: begin
        sum_a_d = cmd_i.data;
        sum_b_d = cmd_i.data;
      end
      OP_SUM, OP_PAYLOAD: begin
        sum_a_d = sum_a_q + cmd_i.data;
        sum_b_d = sum_b_q + sum_a_d;
      end
      OP_CK_B: begin
        kind_d = ((sum_a_q == ck_lo_q) && (sum_b_q == cmd_i.data)) ? KIND_GOOD : KIND_BAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q     <= 8'h00;
      sum_b_q     <= 8'h00;
      ck_lo_q     <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        sum_a_q <= sum_a_d;
        sum_b_q <= sum_b_d;
        if (cmd_i.op == OP_CK_A) begin
          ck_lo_q <= cmd_i.data;
        end
      end
      if (pop && emits) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emits) begin
      kind_q  <= kind_d;
      class_q <= cmd_i.frame_class;
      id_q    <= cmd_i.frame_id;
      len_q   <= cmd_i.frame_length;
      idx_q   <= (cmd_i.op == OP_PAYLOAD) ? cmd_i.byte_index : 16'h0000;
      data_q  <= (cmd_i.op == OP_PAYLOAD) ? cmd_i.data : 8'h00;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_kind  = kind_q;
  assign res_o.frame_class  = class_q;
  assign res_o.frame_id     = id_q;
  assign res_o.frame_length = len_q;
  assign res_o.byte_index   = idx_q;
  assign res_o.data_byte    = data_q;

endmodule

// File: hdl/ubx_frame_deframer.sv
// Top level of the binary frame deframer: config register, front end, queue, back end.
// Depends on ufd_pkg, ufd_if, ufd_front, ufd_cmd_fifo and ufd_back.
//
// Accepts one received byte per cycle with no gaps of its own; a payload byte or a
// frame verdict goes into the command queue, then the back end's result register.
// The parser front end and the checksum back end each run one byte per cycle unless
// stalled, and meet through a QUEUE_DEPTH-entry command queue, so result stalls reach
// the byte input only once it is full. Oversized frames and bad sync give no result.
module ubx_frame_deframer
  import ufd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ufd_byte_if.sink     rx_i,
  ufd_cfg_if.sink      cfg_i,
  ufd_result_if.source res_o
);

  logic [15:0] max_len_q;
  logic        f_cmd_valid, f_cmd_ready;
  cmd_t        f_cmd;
  logic        b_cmd_valid, b_cmd_ready;
  cmd_t        b_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_payload_len;
    end
  end

  ufd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .max_len_i   (max_len_q),
    .cmd_valid_o (f_cmd_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_cmd_ready)
  );

  ufd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_cmd_valid),
    .push_ready_o (f_cmd_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_cmd_valid),
    .pop_ready_i  (b_cmd_ready),
    .pop_data_o   (b_cmd)
  );

  ufd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_cmd_valid),
    .cmd_i       (b_cmd),
    .cmd_ready_o (b_cmd_ready),
    .res_o       (res_o)
  );

endmodule
